// ===== design/bspd_pkg.sv =====
// ----------------------------------------------------------------------------
// bspd_pkg
// Shared widths, sizes and types of the boxcar slope peak detector.
// ----------------------------------------------------------------------------
package bspd_pkg;

    localparam int SMP_W  = 24;
    localparam int CHAN_W = 10;
    localparam int SCAN_W = 16;
    localparam int CNT_W  = 17;
    localparam int WIN_W  = 4;
    localparam int CFG_W  = 24;

    localparam int LOCAL_MAX_RADIUS = 4;
    localparam int WINDOW_MAX       = 15;
    localparam int MAX_SCANS        = 65536;
    localparam int WIN_RESET        = 2;

    localparam int LAG_MAX = (WINDOW_MAX + 2 > LOCAL_MAX_RADIUS) ?
                             WINDOW_MAX + 2 : LOCAL_MAX_RADIUS;
    localparam int REACH   = (WINDOW_MAX + 1 > LOCAL_MAX_RADIUS) ?
                             WINDOW_MAX + 1 : LOCAL_MAX_RADIUS;
    localparam int NCELL   = LAG_MAX + REACH + 1;
    localparam int TAP_W   = $clog2(NCELL);
    localparam int LAG_W   = $clog2(LAG_MAX + 1);
    localparam int NWIN    = 2 * LOCAL_MAX_RADIUS + 1;
    localparam int NLEAF   = 2 ** $clog2(NWIN);
    localparam int LEAF_W  = $clog2(NLEAF);

    typedef logic [SMP_W-1:0] t_smp;
    typedef logic [NCELL-1:0][SMP_W-1:0] t_row;
    typedef logic [NWIN-1:0][SMP_W-1:0] t_win;

    typedef struct packed {
        logic              vld;
        logic              flush;
        logic [CHAN_W-1:0] chan;
        logic [SCAN_W-1:0] scan;
        t_win              win;
    } t_cand;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [SCAN_W-1:0] scan;
        t_smp              val;
    } t_res;

endpackage

// ===== design/boxcar_slope_peak_detector.sv =====
// ----------------------------------------------------------------------------
// boxcar_slope_peak_detector
// Reports local intensity peaks of one mass channel's trace where the boxcar
// difference turns from rising to falling. Samples enter a line of 34 cells
// that shift once per accepted sample among the first 65536 of a trace, and
// a decision runs through a slope stage and a peak stage before it reaches
// the output register. The block takes one sample per cycle for as long as
// the output side takes results. A sample that carries the last mark starts
// a flush that shifts zeros through the cells to decide the pending scans;
// the block is ready again once the flush and the stage drain are done.
// ----------------------------------------------------------------------------
module boxcar_slope_peak_detector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bspd_pkg::CHAN_W-1:0] i_mass_channel,
    input  logic [bspd_pkg::SMP_W-1:0]  i_sample_intensity,
    input  logic                        i_last_sample,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bspd_pkg::CHAN_W-1:0] o_out_channel,
    output logic [bspd_pkg::SCAN_W-1:0] o_peak_scan,
    output logic [bspd_pkg::SMP_W-1:0]  o_peak_intensity,
    output logic                        o_last_result,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [bspd_pkg::CFG_W-1:0]  i_cfg_data
);
    import bspd_pkg::*;

    localparam logic CFG_WIN = 1'b0;
    localparam logic CFG_THR = 1'b1;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [WIN_W-1:0]  r_win;
    t_smp              r_thr;
    logic [1:0]        r_state, n_state;
    logic              r_eval, n_eval;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_vcnt, n_vcnt;
    logic [CHAN_W-1:0] r_chan, n_chan;
    logic              r_out_valid, n_out_valid;
    t_res              r_out, n_out;
    logic              r_out_last, n_out_last;
    t_res              r_hold, n_hold;
    logic              r_hold_vld, n_hold_vld;

    logic [WIN_W-1:0]  w_eff;
    logic [LAG_W-1:0]  w2;
    logic [LAG_W-1:0]  lag;
    logic              en;
    logic              acc;
    logic              stored;
    logic              eval_ok;
    logic [SCAN_W-1:0] scan_s;
    logic              more;
    logic              pipe_empty;
    logic              drain_done;
    logic              shift;
    logic              clr;

    logic [NCELL-1:0]  cv;
    t_row              cd;
    t_row              row;
    t_cand             cand;
    t_res              res;
    logic              hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_W'(WIN_RESET);
            r_thr <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIN: r_win <= i_cfg_data[WIN_W-1:0];
                CFG_THR: r_thr <= i_cfg_data[SMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff      = (r_win > WIN_W'(WINDOW_MAX)) ? WIN_W'(WINDOW_MAX) : r_win;
        w2         = LAG_W'(w_eff) + LAG_W'(2);
        lag        = (w2 > LAG_W'(LOCAL_MAX_RADIUS)) ? w2 : LAG_W'(LOCAL_MAX_RADIUS);
        en         = !r_out_valid || i_out_ready;
        o_in_ready = (r_state == ST_RUN) && en;
        acc        = i_in_valid && o_in_ready;
        stored     = r_cnt < CNT_W'(MAX_SCANS);
        eval_ok    = r_eval && (r_vcnt >= CNT_W'(lag) + CNT_W'(2));
        scan_s     = SCAN_W'(r_vcnt - CNT_W'(lag) - CNT_W'(1));
        more       = ({1'b0, r_vcnt} + (CNT_W+1)'(4)) <= ({1'b0, r_cnt} + (CNT_W+1)'(lag));
        pipe_empty = !r_eval && !cand.vld;
        drain_done = (r_state == ST_DRAIN) && pipe_empty;
    end

    always_comb begin
        n_state = r_state;
        n_eval  = r_eval;
        n_cnt   = r_cnt;
        n_vcnt  = r_vcnt;
        n_chan  = r_chan;
        shift   = 1'b0;
        clr     = 1'b0;
        if (en) begin
            unique case (r_state)
                ST_RUN: begin
                    n_eval = 1'b0;
                    if (acc) begin
                        n_chan = i_mass_channel;
                        n_eval = stored;
                        if (stored) begin
                            shift  = 1'b1;
                            n_cnt  = r_cnt + CNT_W'(1);
                            n_vcnt = r_vcnt + CNT_W'(1);
                        end
                        if (i_last_sample) begin
                            n_state = ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (more) begin
                        shift  = 1'b1;
                        n_vcnt = r_vcnt + CNT_W'(1);
                        n_eval = 1'b1;
                    end else begin
                        n_eval  = 1'b0;
                        n_state = ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (pipe_empty) begin
                        clr     = 1'b1;
                        n_cnt   = '0;
                        n_vcnt  = '0;
                        n_state = ST_RUN;
                    end
                end
                default: n_state = ST_RUN;
            endcase
        end
    end

    always_comb begin
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid;
        n_hold      = r_hold;
        n_hold_vld  = r_hold_vld;
        if (en) begin
            n_out_valid = 1'b0;
            if (hit) begin
                if (!cand.flush) begin
                    n_out       = res;
                    n_out_last  = 1'b1;
                    n_out_valid = 1'b1;
                end else begin
                    if (r_hold_vld) begin
                        n_out       = r_hold;
                        n_out_last  = 1'b0;
                        n_out_valid = 1'b1;
                    end
                    n_hold     = res;
                    n_hold_vld = 1'b1;
                end
            end
            if (drain_done && r_hold_vld) begin
                n_out       = r_hold;
                n_out_last  = 1'b1;
                n_out_valid = 1'b1;
                n_hold_vld  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_eval      <= 1'b0;
            r_cnt       <= '0;
            r_vcnt      <= '0;
            r_out_valid <= 1'b0;
            r_hold_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_eval      <= n_eval;
            r_cnt       <= n_cnt;
            r_vcnt      <= n_vcnt;
            r_out_valid <= n_out_valid;
            r_hold_vld  <= n_hold_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chan     <= n_chan;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_hold     <= n_hold;
    end

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        if (k == 0) begin : g_head
            bspd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_clr   (clr),
                .i_vld   (r_state == ST_RUN),
                .i_data  (i_sample_intensity),
                .o_vld   (cv[k]),
                .o_data  (cd[k]),
                .o_val   (row[k])
            );
        end else begin : g_body
            bspd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_clr   (clr),
                .i_vld   (cv[k-1]),
                .i_data  (cd[k-1]),
                .o_vld   (cv[k]),
                .o_data  (cd[k]),
                .o_val   (row[k])
            );
        end
    end

    bspd_slope u_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_eval  (eval_ok),
        .i_flush (r_state == ST_FLUSH),
        .i_chan  (r_chan),
        .i_scan  (scan_s),
        .i_w     (w_eff),
        .i_lag   (lag),
        .i_row   (row),
        .o_cand  (cand)
    );

    bspd_peak u_peak (
        .i_cand (cand),
        .i_thr  (r_thr),
        .o_res  (res),
        .o_hit  (hit)
    );

    assign o_out_valid      = r_out_valid;
    assign o_out_channel    = r_out.chan;
    assign o_peak_scan      = r_out.scan;
    assign o_peak_intensity = r_out.val;
    assign o_last_result    = r_out_last;

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !r_hold_vld)
        else $error("Held flush result survived into normal operation.");

    a_count_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_vcnt == r_cnt))
        else $error("Shift count and sample count disagree outside a flush.");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_SCANS))
        else $error("Sample count ran past the trace limit.");

endmodule

// ===== design/bspd_cell.sv =====
// ----------------------------------------------------------------------------
// bspd_cell
// One stage of the sample line: holds one sample and its in-trace flag.
// ----------------------------------------------------------------------------
module bspd_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  logic           i_clr,
    input  logic           i_vld,
    input  bspd_pkg::t_smp i_data,
    output logic           o_vld,
    output bspd_pkg::t_smp o_data,
    output bspd_pkg::t_smp o_val
);
    import bspd_pkg::*;

    logic r_vld;
    t_smp r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;
    assign o_val  = r_vld ? r_data : '0;

endmodule

// ===== design/bspd_slope.sv =====
// ----------------------------------------------------------------------------
// bspd_slope
// Picks the boxcar taps from the sample line, tests the slope sign change
// and registers the candidate with its local window.
// ----------------------------------------------------------------------------
module bspd_slope (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_eval,
    input  logic                         i_flush,
    input  logic [bspd_pkg::CHAN_W-1:0]  i_chan,
    input  logic [bspd_pkg::SCAN_W-1:0]  i_scan,
    input  logic [bspd_pkg::WIN_W-1:0]   i_w,
    input  logic [bspd_pkg::LAG_W-1:0]   i_lag,
    input  bspd_pkg::t_row               i_row,
    output bspd_pkg::t_cand              o_cand
);
    import bspd_pkg::*;

    logic [TAP_W-1:0] lag_t;
    logic [TAP_W-1:0] w_t;
    logic [TAP_W-1:0] ia0, ia1, ia2, ib0, ib1, ib2;
    t_smp             a0, a1, a2, b0, b1, b2;
    logic             slope_ok;
    t_win             win;
    logic             r_vld;
    t_cand            r_pay;

    always_comb begin
        lag_t = TAP_W'(i_lag);
        w_t   = TAP_W'(i_w);
        ia0   = lag_t - w_t;
        ia1   = lag_t - w_t - TAP_W'(1);
        ia2   = lag_t - w_t - TAP_W'(2);
        ib0   = lag_t + w_t + TAP_W'(1);
        ib1   = lag_t + w_t;
        ib2   = lag_t + w_t - TAP_W'(1);
        a0    = i_row[ia0];
        a1    = i_row[ia1];
        a2    = i_row[ia2];
        b0    = i_row[ib0];
        b1    = i_row[ib1];
        b2    = i_row[ib2];
        slope_ok = (a0 > b0) && ((a1 < b1) || ((a1 == b1) && (a2 < b2)));
        for (int j = 0; j < NWIN; j++) begin
            win[j] = i_row[lag_t + TAP_W'(LOCAL_MAX_RADIUS) - TAP_W'(j)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_eval && slope_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay.vld   <= 1'b0;
            r_pay.flush <= i_flush;
            r_pay.chan  <= i_chan;
            r_pay.scan  <= i_scan;
            r_pay.win   <= win;
        end
    end

    always_comb begin
        o_cand     = r_pay;
        o_cand.vld = r_vld;
    end

endmodule

// ===== design/bspd_peak.sv =====
// ----------------------------------------------------------------------------
// bspd_peak
// Finds the first maximum of a candidate's window and applies the threshold.
// ----------------------------------------------------------------------------
module bspd_peak (
    input  bspd_pkg::t_cand i_cand,
    input  bspd_pkg::t_smp  i_thr,
    output bspd_pkg::t_res  o_res,
    output logic            o_hit
);
    import bspd_pkg::*;

    t_smp              v [NLEAF];
    logic [LEAF_W-1:0] x [NLEAF];

    always_comb begin
        for (int i = 0; i < NWIN; i++) begin
            v[i] = i_cand.win[i];
        end
        for (int i = NWIN; i < NLEAF; i++) begin
            v[i] = '0;
        end
        for (int i = 0; i < NLEAF; i++) begin
            x[i] = LEAF_W'(i);
        end
        for (int st = 1; st < NLEAF; st = st * 2) begin
            for (int i = 0; i < NLEAF; i = i + 2 * st) begin
                if (v[i+st] > v[i]) begin
                    v[i] = v[i+st];
                    x[i] = x[i+st];
                end
            end
        end
        o_res.chan = i_cand.chan;
        o_res.val  = v[0];
        o_res.scan = (v[0] == '0) ? i_cand.scan :
                     i_cand.scan + SCAN_W'(x[0]) - SCAN_W'(LOCAL_MAX_RADIUS);
        o_hit      = i_cand.vld && (v[0] >= i_thr);
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the boxcar slope peak detector. Intensity traces
// are streamed in under random stalls on both sides. A predictor tracks the
// sample history and the registers, derives every peak report that an
// accepted sample should cause, and each report that comes out is checked
// field by field against the oldest one still expected. The window and
// threshold registers are rewritten between traces and in the middle of
// some traces.
// ----------------------------------------------------------------------------
module testbench;
    import bspd_pkg::*;

    localparam int HIST_DEPTH    = 64;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 135;

    localparam logic REG_WINDOW   = 1'b0;
    localparam logic REG_MIN_PEAK = 1'b1;

    typedef struct {
        logic [CHAN_W-1:0] chan;
        logic [SMP_W-1:0]  smp;
        logic              last;
    } sample_t;

    typedef struct {
        logic [CHAN_W-1:0] chan;
        logic [SCAN_W-1:0] scan;
        logic [SMP_W-1:0]  val;
        logic              last;
    } peak_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [CHAN_W-1:0] i_mass_channel = '0;
    logic [SMP_W-1:0]  i_sample_intensity = '0;
    logic              i_last_sample = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [CHAN_W-1:0] o_out_channel;
    logic [SCAN_W-1:0] o_peak_scan;
    logic [SMP_W-1:0]  o_peak_intensity;
    logic              o_last_result;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    boxcar_slope_peak_detector dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mass_channel     (i_mass_channel),
        .i_sample_intensity (i_sample_intensity),
        .i_last_sample      (i_last_sample),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_channel      (o_out_channel),
        .o_peak_scan        (o_peak_scan),
        .o_peak_intensity   (o_peak_intensity),
        .o_last_result      (o_last_result),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    sample_t sample_q[$];
    peak_t   peak_expect_q[$];

    logic [SMP_W-1:0] hist [HIST_DEPTH];
    logic [CNT_W-1:0] scan_cnt = '0;
    logic [WIN_W-1:0] win_cfg = WIN_W'(WIN_RESET);
    logic [SMP_W-1:0] thr_cfg = '0;

    int send_idle_pct = 13;
    int recv_idle_pct = 62;
    int items_queued = 0;
    int items_taken = 0;
    int reports_checked = 0;
    int traces = 0;
    int cfg_writes = 0;
    int errors = 0;
    int cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int sample_at(input int i, input int n);
        if (i < 0 || i >= n)
            return 0;
        return int'(hist[i % HIST_DEPTH]);
    endfunction

    function automatic bit judge_scan(input int s, input int n, input int w,
                                      input logic [CHAN_W-1:0] chan, output peak_t p);
        int d0, d1, d2, best, pos;
        p = '{default: '0};
        if (s < 1 || s >= n - 3)
            return 0;
        d0 = sample_at(s + w, n) - sample_at(s - w - 1, n);
        d1 = sample_at(s + w + 1, n) - sample_at(s - w, n);
        d2 = sample_at(s + w + 2, n) - sample_at(s - w + 1, n);
        if (!(d0 > 0 && (d1 < 0 || (d1 == 0 && d2 < 0))))
            return 0;
        best = 0;
        pos = s;
        for (int i = s - LOCAL_MAX_RADIUS; i <= s + LOCAL_MAX_RADIUS; i++) begin
            if (sample_at(i, n) > best) begin
                best = sample_at(i, n);
                pos = i;
            end
        end
        if (best < int'(thr_cfg))
            return 0;
        p.chan = chan;
        p.scan = pos[SCAN_W-1:0];
        p.val = best[SMP_W-1:0];
        p.last = 1'b0;
        return 1;
    endfunction

    task automatic predict_peaks(input sample_t it);
        bit stored;
        int w, lag, n, first;
        peak_t p;
        peak_t found[$];
        stored = scan_cnt < MAX_SCANS;
        w = (win_cfg > WINDOW_MAX) ? WINDOW_MAX : int'(win_cfg);
        lag = (w + 2 > LOCAL_MAX_RADIUS) ? w + 2 : LOCAL_MAX_RADIUS;
        if (stored) begin
            hist[scan_cnt % HIST_DEPTH] = it.smp;
            scan_cnt++;
        end
        n = int'(scan_cnt);
        if (!it.last) begin
            if (stored && judge_scan(n - 1 - lag, n, w, it.chan, p))
                found.push_back(p);
        end else begin
            first = stored ? n - 1 - lag : n - lag;
            if (first < 1)
                first = 1;
            for (int s = first; s <= n - 4; s++) begin
                if (judge_scan(s, n, w, it.chan, p))
                    found.push_back(p);
            end
            scan_cnt = '0;
        end
        if (found.size() != 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[k])
            peak_expect_q.push_back(found[k]);
    endtask

    always @(posedge i_clk) begin : driver
        sample_t cur;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_peaks(cur);
                items_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur = sample_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_mass_channel <= cur.chan;
                    i_sample_intensity <= cur.smp;
                    i_last_sample <= cur.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        peak_t e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (peak_expect_q.size() == 0) begin
                    $error("Unexpected peak report: channel %0d scan %0d intensity %0d",
                           o_out_channel, o_peak_scan, o_peak_intensity);
                    errors++;
                end else begin
                    e = peak_expect_q.pop_front();
                    reports_checked++;
                    if (o_out_channel !== e.chan) begin
                        $error("out_channel: expected %0d, got %0d", e.chan, o_out_channel);
                        errors++;
                    end
                    if (o_peak_scan !== e.scan) begin
                        $error("peak_scan: expected %0d, got %0d", e.scan, o_peak_scan);
                        errors++;
                    end
                    if (o_peak_intensity !== e.val) begin
                        $error("peak_intensity: expected %0d, got %0d",
                               e.val, o_peak_intensity);
                        errors++;
                    end
                    if (o_last_result !== e.last) begin
                        $error("last_result: expected %0d, got %0d", e.last, o_last_result);
                        errors++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_sample(input logic [CHAN_W-1:0] chan, input logic [SMP_W-1:0] smp,
                               input logic last);
        sample_t it;
        it.chan = chan;
        it.smp = smp;
        it.last = last;
        sample_q.push_back(it);
        items_queued++;
    endtask

    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (items_taken != items_queued || peak_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WINDOW)
            win_cfg = data[WIN_W-1:0];
        else
            thr_cfg = data[SMP_W-1:0];
        cfg_writes++;
    endtask

    task automatic new_setting();
        int r;
        r = $urandom_range(9);
        write_reg(REG_WINDOW, (r == 0) ? 24'd0 : (r == 1) ? 24'd15 :
                  24'($urandom_range(0, 15)));
        r = $urandom_range(9);
        write_reg(REG_MIN_PEAK, (r < 4) ? 24'd0 : (r == 4) ? 24'hFFFFFF :
                  (r < 7) ? 24'($urandom_range(1, 255)) :
                  24'($urandom >> $urandom_range(8, 20)));
    endtask

    task automatic push_trace(input int len, input int split_at);
        int shape, base, noise, lvl, v, gap;
        int bc[3], bh[3], bw[3];
        logic [CHAN_W-1:0] chan;
        shape = $urandom_range(9);
        base = $urandom_range(0, 40);
        noise = ($urandom_range(3) == 0) ? 255 : 3;
        lvl = 0;
        chan = CHAN_W'($urandom_range(0, 1023));
        for (int b = 0; b < 3; b++) begin
            bc[b] = $urandom_range(0, len);
            bh[b] = $urandom_range(1, (1 << $urandom_range(4, 24)) - 1);
            bw[b] = $urandom_range(1, 6);
        end
        for (int i = 0; i < len; i++) begin
            if (i == split_at) begin
                wait_idle();
                new_setting();
            end
            if (shape < 6) begin
                v = base + $urandom_range(0, noise);
                for (int b = 0; b < 3; b++) begin
                    gap = (i > bc[b]) ? i - bc[b] : bc[b] - i;
                    if (gap < bw[b])
                        v += bh[b] - (bh[b] / bw[b]) * gap;
                end
            end else if (shape < 8) begin
                if ($urandom_range(3) != 0)
                    v = 0;
                else if ($urandom_range(7) == 0)
                    v = 24'hFFFFFF;
                else
                    v = $urandom_range(1, 24'hFFFFFF);
            end else if (shape == 8) begin
                if ($urandom_range(3) == 0)
                    lvl = $urandom_range(0, 4) * $urandom_range(1, 5000);
                v = lvl;
            end else begin
                v = $urandom & 24'hFFFFFF;
            end
            if (v > 24'hFFFFFF)
                v = 24'hFFFFFF;
            push_sample(($urandom_range(19) == 0) ? 10'($urandom) : chan, v[SMP_W-1:0],
                        i == len - 1);
        end
        traces++;
    endtask

    task automatic run_random(input int quota);
        int done, len, r, split;
        done = 0;
        while (done < quota) begin
            if ($urandom_range(3) == 0) begin
                wait_idle();
                new_setting();
            end
            r = $urandom_range(99);
            if (r < 8)
                len = $urandom_range(1, 4);
            else if (r < 90)
                len = $urandom_range(5, 40);
            else
                len = $urandom_range(41, 90);
            split = (len >= 10 && $urandom_range(7) == 0) ? $urandom_range(2, len - 2) : -1;
            push_trace(len, split);
            done += len;
            if ($urandom_range(11) == 0)
                wait_idle();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A lone full-scale spike, then a trace too short to report anything.
        for (int i = 0; i < 8; i++)
            push_sample(10'd1023, (i == 3) ? 24'hFFFFFF : 24'd0, i == 7);
        push_sample(10'd0, 24'd5, 1'b0);
        push_sample(10'd0, 24'd100, 1'b0);
        push_sample(10'd0, 24'd7, 1'b0);
        push_sample(10'd0, 24'd1, 1'b1);
        wait_idle();

        // Two spikes one boxcar apart make a candidate whose whole
        // neighborhood is zero, reported at its own scan with intensity 0.
        write_reg(REG_WINDOW, 24'd5);
        write_reg(REG_MIN_PEAK, 24'd0);
        for (int i = 0; i < 13; i++)
            push_sample(10'h155, (i == 1) ? 24'd50 : (i == 11) ? 24'd70 : 24'd0, i == 12);
        traces += 3;
        wait_idle();

        run_random(PHASE_ITEMS);
        wait_idle();
        send_idle_pct = 62;
        recv_idle_pct = 13;
        run_random(PHASE_ITEMS);
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        wait_idle();

        $display("Checked %0d peak reports from %0d samples in %0d traces, %0d register writes.",
                 reports_checked, items_taken, traces, cfg_writes);
        $display("Covered windows 0 to 15, thresholds up to full scale, short traces, "
                 , "window changes inside a trace and stalls on each side.");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
